FILE: src/tracker_pattern_event_decoder_assert.svh
// Assertion macros used by the checker file of the pattern decoder
`ifndef TRACKER_PATTERN_EVENT_DECODER_ASSERT_SVH
`define TRACKER_PATTERN_EVENT_DECODER_ASSERT_SVH

// Check a property on every rising edge outside of reset
`define TPED_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("tped assertion failed");

// Check an implication on every rising edge outside of reset
`define TPED_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  `TPED_ASSERT(lbl, clk_s, rst_s, (ante) |-> (cons))

`endif

FILE: src/tped_pkg.sv
// Types and constants of the tracker pattern decoder
`timescale 1ns / 1ps

package tped_pkg;

  // Byte codes seen at the start of a cell
  localparam logic [7:0] MARK_LO   = 8'd251;
  localparam logic [7:0] MARK_HI   = 8'd253;
  localparam logic [7:0] NOTE_NONE = 8'd255;
  localparam logic [7:0] NOTE_ZERO = 8'd0;

  // Effect and volume limits
  localparam logic [3:0] FX_NONE  = 4'd0;
  localparam logic [3:0] FX_SPEED = 4'd1;
  localparam logic [3:0] FX_COUNT = 4'd10;
  localparam logic [6:0] VOL_MAX  = 7'd64;

  // One decoded cell
  typedef struct packed {
    logic [7:0] note;
    logic [4:0] instrument;
    logic [6:0] volume;
    logic [3:0] effect;
    logic [7:0] effect_param;
    logic [1:0] channel;
    logic [5:0] row;
    logic       pattern_end;
  } cell_t;

  // Note byte to note number: 1 + low nibble + 12 * (2 + high nibble)
  function automatic logic [7:0] note_of(input logic [7:0] b);
    logic [7:0] octave;
    begin
      octave = 8'({4'b0000, b[7:4]} * 8'd12);
      if (b == NOTE_ZERO || b == NOTE_NONE) begin
        note_of = 8'd0;
      end else begin
        note_of = octave + 8'd25 + {4'b0000, b[3:0]};
      end
    end
  endfunction

endpackage

FILE: src/tped_if.sv
// Valid/ready channels for pattern bytes and decoded cells
`timescale 1ns / 1ps

interface tped_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tped_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] note;
  logic [4:0] instrument;
  logic [6:0] volume;
  logic [3:0] effect;
  logic [7:0] effect_param;
  logic [1:0] channel;
  logic [5:0] row;
  logic       pattern_end;

  modport source (output valid, output note, output instrument, output volume,
                  output effect, output effect_param, output channel, output row,
                  output pattern_end, input ready);
  modport sink   (input valid, input note, input instrument, input volume,
                  input effect, input effect_param, input channel, input row,
                  input pattern_end, output ready);
endinterface

FILE: src/tracker_pattern_event_decoder.sv
// Top level of the packed tracker pattern decoder
`timescale 1ns / 1ps

// Takes packed pattern data one byte per word on in_ch and delivers one
// decoded cell per word on out_ch, visiting channels first, then rows, and
// flagging the last cell of each pattern with pattern_end. A marker byte
// (251 to 253) at the start of a cell yields an empty cell from that byte
// alone; any other start byte opens a four-byte cell that is delivered after
// its fourth byte. The block takes one byte every cycle while out_ch is not
// stalled: each byte passes an input register, the field step, and an output
// register, so a cell is shown on out_ch from the output register once its
// last byte has been consumed by the field step. The two registers are the
// only buffering, so a stall on out_ch stops input only when both are full.
module tracker_pattern_event_decoder #(
  parameter int CHANNELS = 4,
  parameter int ROWS     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  tped_in_if.sink           in_ch,
  tped_out_if.source        out_ch
);

  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic            out_valid_r, out_valid_nxt;
  tped_pkg::cell_t out_cell_r;

  logic            consume;
  logic            cell_done;
  tped_pkg::cell_t step_cell;

  // Consume the held byte when the output register is free or being drained
  assign consume     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || consume;

  tped_field_step #(
    .CHANNELS (CHANNELS),
    .ROWS     (ROWS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (consume),
    .stream_byte (in_byte_r),
    .cell_done   (cell_done),
    .dec_cell    (step_cell)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.stream_byte;
    end
  end

  // Output register: load a finished cell, drop a taken one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume) begin
      out_valid_nxt = cell_done;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && cell_done) begin
      out_cell_r <= step_cell;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.note         = out_cell_r.note;
  assign out_ch.instrument   = out_cell_r.instrument;
  assign out_ch.volume       = out_cell_r.volume;
  assign out_ch.effect       = out_cell_r.effect;
  assign out_ch.effect_param = out_cell_r.effect_param;
  assign out_ch.channel      = out_cell_r.channel;
  assign out_ch.row          = out_cell_r.row;
  assign out_ch.pattern_end  = out_cell_r.pattern_end;

endmodule

FILE: src/tped_field_step.sv
// Per-byte field step: cell assembly state and channel/row position
`timescale 1ns / 1ps

module tped_field_step #(
  parameter int CHANNELS = 4,
  parameter int ROWS     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          stream_byte,
  output logic                cell_done,
  output tped_pkg::cell_t     dec_cell
);

  localparam logic [1:0] POS_NOTE  = 2'd0;
  localparam logic [1:0] POS_INSTR = 2'd1;
  localparam logic [1:0] POS_VOLFX = 2'd2;
  localparam logic [1:0] POS_PARAM = 2'd3;

  localparam logic [1:0] CH_LAST  = 2'(CHANNELS - 1);
  localparam logic [5:0] ROW_LAST = 6'(ROWS - 1);

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] note_r, note_nxt;
  logic [4:0] ins_r, ins_nxt;
  logic [6:0] vol_r, vol_nxt;
  logic [3:0] fx_r, fx_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic [5:0] row_r, row_nxt;

  logic       is_marker;
  logic [6:0] vol_sum;

  assign is_marker = stream_byte inside {[tped_pkg::MARK_LO:tped_pkg::MARK_HI]};
  assign vol_sum   = vol_r + {stream_byte[7:4], 3'b000};

  // Decode one byte at the current position within the cell
  always_comb begin
    pos_nxt   = pos_r;
    note_nxt  = note_r;
    ins_nxt   = ins_r;
    vol_nxt   = vol_r;
    fx_nxt    = fx_r;
    cell_done = 1'b0;
    dec_cell.note         = note_r;
    dec_cell.instrument   = ins_r;
    dec_cell.volume       = vol_r;
    dec_cell.effect       = fx_r;
    dec_cell.effect_param = stream_byte;
    case (pos_r)
      POS_NOTE: begin
        if (is_marker) begin
          // empty cell right away
          cell_done             = 1'b1;
          dec_cell.note         = 8'd0;
          dec_cell.instrument   = 5'd0;
          dec_cell.volume       = 7'd0;
          dec_cell.effect       = tped_pkg::FX_NONE;
          dec_cell.effect_param = 8'd0;
        end else begin
          note_nxt = tped_pkg::note_of(stream_byte);
          pos_nxt  = POS_INSTR;
        end
      end
      POS_INSTR: begin
        vol_nxt = {4'b0000, stream_byte[2:0]};
        ins_nxt = stream_byte[7:3];
        pos_nxt = POS_VOLFX;
      end
      POS_VOLFX: begin
        vol_nxt = (vol_sum > tped_pkg::VOL_MAX) ? 7'd0 : vol_sum + 7'd1;
        fx_nxt  = (stream_byte[3:0] < tped_pkg::FX_COUNT) ? stream_byte[3:0]
                                                           : tped_pkg::FX_NONE;
        pos_nxt = POS_PARAM;
      end
      POS_PARAM: begin
        // set speed keeps only the high nibble
        if (fx_r == tped_pkg::FX_SPEED) begin
          dec_cell.effect_param = {4'b0000, stream_byte[7:4]};
        end
        cell_done = 1'b1;
        pos_nxt   = POS_NOTE;
      end
      default: begin
        pos_nxt = POS_NOTE;
      end
    endcase
    dec_cell.channel     = chan_r;
    dec_cell.row         = row_r;
    dec_cell.pattern_end = (chan_r == CH_LAST) && (row_r == ROW_LAST);
  end

  // Advance channel first, then row, wrapping both
  always_comb begin
    chan_nxt = chan_r;
    row_nxt  = row_r;
    if (cell_done) begin
      if (chan_r == CH_LAST) begin
        chan_nxt = 2'd0;
        row_nxt  = (row_r == ROW_LAST) ? 6'd0 : row_r + 6'd1;
      end else begin
        chan_nxt = chan_r + 2'd1;
      end
    end
  end

  // Hold state until a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_NOTE;
      note_r <= 8'd0;
      ins_r  <= 5'd0;
      vol_r  <= 7'd0;
      fx_r   <= tped_pkg::FX_NONE;
      chan_r <= 2'd0;
      row_r  <= 6'd0;
    end else if (step_en) begin
      pos_r  <= pos_nxt;
      note_r <= note_nxt;
      ins_r  <= ins_nxt;
      vol_r  <= vol_nxt;
      fx_r   <= fx_nxt;
      chan_r <= chan_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

FILE: src/tped_checker.sv
// Port-level checks of the pattern decoder and their bind
`timescale 1ns / 1ps
`include "tracker_pattern_event_decoder_assert.svh"

module tped_checker #(
  parameter int CHANNELS = 4,
  parameter int ROWS     = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_note,
  input logic [4:0] out_instrument,
  input logic [6:0] out_volume,
  input logic [3:0] out_effect,
  input logic [7:0] out_effect_param,
  input logic [1:0] out_channel,
  input logic [5:0] out_row,
  input logic       out_pattern_end
);

  localparam logic [1:0] CH_LAST  = 2'(CHANNELS - 1);
  localparam logic [5:0] ROW_LAST = 6'(ROWS - 1);

  logic [1:0]  exp_chan_r;
  logic [5:0]  exp_row_r;
  logic [40:0] out_word;
  logic        at_exp_pos;
  logic        end_ok;
  logic        range_ok;

  // Gather the delivered word and the per-cycle checks
  assign out_word   = {out_note, out_instrument, out_volume, out_effect,
                       out_effect_param, out_channel, out_row, out_pattern_end};
  assign at_exp_pos = (out_channel == exp_chan_r) && (out_row == exp_row_r);
  assign end_ok     = out_pattern_end == ((out_channel == CH_LAST) && (out_row == ROW_LAST));
  assign range_ok   = (out_volume <= 7'd65) && (out_effect < 4'd10) && (out_note <= 8'd219);

  // Track where the next delivered cell must sit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_chan_r <= 2'd0;
      exp_row_r  <= 6'd0;
    end else if (out_valid && out_ready) begin
      if (exp_chan_r == CH_LAST) begin
        exp_chan_r <= 2'd0;
        exp_row_r  <= (exp_row_r == ROW_LAST) ? 6'd0 : exp_row_r + 6'd1;
      end else begin
        exp_chan_r <= exp_chan_r + 2'd1;
      end
    end
  end

  // A stalled word holds
  `TPED_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))

  // Cells arrive in channel-then-row order with no gap
  `TPED_ASSERT_IMP(a_cell_order, clk, rst_n, out_valid, at_exp_pos)

  // End flag marks exactly the last channel of the last row
  `TPED_ASSERT_IMP(a_pattern_end, clk, rst_n, out_valid, end_ok)

  // Decoded fields stay in their ranges
  `TPED_ASSERT_IMP(a_field_range, clk, rst_n, out_valid, range_ok)

endmodule

bind tracker_pattern_event_decoder tped_checker #(
  .CHANNELS (CHANNELS),
  .ROWS     (ROWS)
) u_tped_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_note         (out_ch.note),
  .out_instrument   (out_ch.instrument),
  .out_volume       (out_ch.volume),
  .out_effect       (out_ch.effect),
  .out_effect_param (out_ch.effect_param),
  .out_channel      (out_ch.channel),
  .out_row          (out_ch.row),
  .out_pattern_end  (out_ch.pattern_end)
);
